@@ design/tcp_ipv4_packet_checker_top_macros.svh @@
// Assertion macros shared by the packet checker modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TCP_IPV4_PACKET_CHECKER_TOP_MACROS_SVH
`define TCP_IPV4_PACKET_CHECKER_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define TCPC_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TCPC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tcpc_pkg.sv @@
// Shared types, status codes and helpers for the IPv4/TCP packet checker.
// No dependencies.
package tcpc_pkg;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_IP_CKSUM  = 3'd2;
    localparam logic [2:0] ST_LENGTH    = 3'd3;
    localparam logic [2:0] ST_NOT_TCP   = 3'd4;
    localparam logic [2:0] ST_TCP_SHORT = 3'd5;
    localparam logic [2:0] ST_TCP_CKSUM = 3'd6;
    localparam logic [2:0] ST_OFFSET    = 3'd7;

    localparam logic [7:0]  PROTO_TCP     = 8'h06;
    localparam logic [15:0] SUM_GOOD      = 16'hffff;
    localparam logic [16:0] MIN_HDR_BYTES = 17'd20;

    typedef struct packed {
        logic [16:0] count;
        logic [15:0] ip_sum;
        logic [15:0] tcp_sum;
        logic [7:0]  pending_high;
        logic [3:0]  header_words;
        logic [15:0] total_len;
        logic [7:0]  proto_byte;
        logic [7:0]  ttl;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [3:0]  data_offset;
        logic [7:0]  flag_byte;
        logic [15:0] window;
    } snap_t;

    typedef struct packed {
        snap_t       snap;
        logic [2:0]  pre_status;
        logic [15:0] addr_sum;
        logic [15:0] len_sum;
        logic [15:0] seg_sum;
        logic [15:0] tcp_len;
    } mid_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  hop_limit;
        logic [15:0] window;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [3:0]  flag_bits;
        logic [6:0]  payload_start;
        logic [15:0] payload_length;
    } res_t;

    function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

@@ design/tcpc_parse.sv @@
// Per-byte header capture, byte count and running checksums of the packet checker.
// Depends on tcpc_pkg and the shared assertion macro header.
`include "tcp_ipv4_packet_checker_top_macros.svh"

module tcpc_parse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         pkt_byte,
    input  logic               is_last,
    output tcpc_pkg::snap_t    snap_next
);

    localparam logic [16:0] MIN_HDR_BYTES_L = tcpc_pkg::MIN_HDR_BYTES;
    localparam logic [16:0] COUNT_LIMIT = 17'h10000;

    tcpc_pkg::snap_t st_reg;
    tcpc_pkg::snap_t st_next;
    logic [16:0]     pos;
    logic [3:0]      hw;
    logic [16:0]     toff;
    logic [16:0]     rel;
    logic [15:0]     word;

    assign pos  = st_reg.count;
    assign hw   = (pos == 17'd0) ? pkt_byte[3:0] : st_reg.header_words;
    assign toff = {11'd0, hw, 2'b00};
    assign rel  = pos - toff;
    assign word = {st_reg.pending_high, pkt_byte};

    always_comb
    begin
        st_next = st_reg;
        if (!pos[16])
        begin
            st_next.header_words = hw;
            case (pos) inside
                17'd2:           st_next.total_len[15:8] = pkt_byte;
                17'd3:           st_next.total_len[7:0]  = pkt_byte;
                17'd8:           st_next.ttl = pkt_byte;
                17'd9:           st_next.proto_byte = pkt_byte;
                [17'd12:17'd15]: st_next.source_ip[{~pos[1:0], 3'b000} +: 8] = pkt_byte;
                [17'd16:17'd19]: st_next.dest_ip[{~pos[1:0], 3'b000} +: 8] = pkt_byte;
                default:         st_next.header_words = hw;
            endcase

            if (pos >= toff && rel < MIN_HDR_BYTES_L)
            begin
                case (rel[4:0]) inside
                    [5'd0:5'd1]:  st_next.source_port[{~rel[0], 3'b000} +: 8] = pkt_byte;
                    [5'd2:5'd3]:  st_next.dest_port[{~rel[0], 3'b000} +: 8] = pkt_byte;
                    [5'd4:5'd7]:  st_next.seq_number[{~rel[1:0], 3'b000} +: 8] = pkt_byte;
                    [5'd8:5'd11]: st_next.ack_number[{~rel[1:0], 3'b000} +: 8] = pkt_byte;
                    5'd12:        st_next.data_offset = pkt_byte[7:4];
                    5'd13:        st_next.flag_byte = pkt_byte;
                    5'd14:        st_next.window[15:8] = pkt_byte;
                    5'd15:        st_next.window[7:0] = pkt_byte;
                    default:      st_next.window = st_reg.window;
                endcase
            end

            if (!pos[0])
            begin
                st_next.pending_high = pkt_byte;
            end
            else
            begin
                if (pos < MIN_HDR_BYTES_L)
                begin
                    st_next.ip_sum = tcpc_pkg::ones_add(st_reg.ip_sum, word);
                end
                if (pos > toff)
                begin
                    st_next.tcp_sum = tcpc_pkg::ones_add(st_reg.tcp_sum, word);
                end
            end
            st_next.count = pos + 17'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (take)
        begin
            st_reg <= is_last ? '0 : st_next;
        end
    end

    assign snap_next = st_next;

    `TCPC_ASSERT_NEXT(a_clear_after_last, take && is_last, st_reg.count == 17'd0,
        "byte count not cleared after the last byte of a packet")
    `TCPC_ASSERT_SAME(a_count_bounded, 1'b1, st_reg.count <= COUNT_LIMIT,
        "byte count went past its saturation point")

endmodule

@@ design/tcpc_verdict.sv @@
// Verdict pipeline of the packet checker: snapshot, checksum merge and result registers.
// Depends on tcpc_pkg and the shared assertion macro header.
`include "tcp_ipv4_packet_checker_top_macros.svh"

module tcpc_verdict (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               snap_valid,
    output logic               snap_ready,
    input  tcpc_pkg::snap_t    snap,
    output logic               out_valid,
    input  logic               out_ready,
    output tcpc_pkg::res_t     result
);

    logic            s1_valid_reg;
    tcpc_pkg::snap_t s1_reg;
    logic            s2_valid_reg;
    tcpc_pkg::mid_t  s2_reg;
    tcpc_pkg::mid_t  s2_next;
    logic            out_valid_reg;
    tcpc_pkg::res_t  out_reg;
    tcpc_pkg::res_t  out_next;
    logic            r1;
    logic            r2;
    logic            r3;

    logic [16:0] cnt1;
    logic [16:0] toff1;
    logic [16:0] tlen1;

    logic [16:0] cnt2;
    logic [5:0]  toff2;
    logic [5:0]  doff2;
    logic [6:0]  pstart;
    logic [15:0] full_sum;
    logic        ack_set;

    assign r3 = !out_valid_reg || out_ready;
    assign r2 = !s2_valid_reg || r3;
    assign r1 = !s1_valid_reg || r2;
    assign snap_ready = r1;

    assign cnt1  = s1_reg.count;
    assign toff1 = {11'd0, s1_reg.header_words, 2'b00};
    assign tlen1 = cnt1 - toff1;

    always_comb
    begin
        s2_next = '0;
        s2_next.snap = s1_reg;
        s2_next.tcp_len = tlen1[15:0];

        if (cnt1[0] && !cnt1[16] && cnt1 > toff1)
        begin
            s2_next.seg_sum = tcpc_pkg::ones_add(s1_reg.tcp_sum, {s1_reg.pending_high, 8'h00});
        end
        else
        begin
            s2_next.seg_sum = s1_reg.tcp_sum;
        end

        s2_next.addr_sum = tcpc_pkg::ones_add(
            tcpc_pkg::ones_add(s1_reg.source_ip[31:16], s1_reg.source_ip[15:0]),
            tcpc_pkg::ones_add(s1_reg.dest_ip[31:16], s1_reg.dest_ip[15:0]));
        s2_next.len_sum = tcpc_pkg::ones_add({8'd0, tcpc_pkg::PROTO_TCP}, tlen1[15:0]);

        if (cnt1 < tcpc_pkg::MIN_HDR_BYTES)
        begin
            s2_next.pre_status = tcpc_pkg::ST_SHORT;
        end
        else if (s1_reg.ip_sum != tcpc_pkg::SUM_GOOD)
        begin
            s2_next.pre_status = tcpc_pkg::ST_IP_CKSUM;
        end
        else if ({1'b0, s1_reg.total_len} != cnt1)
        begin
            s2_next.pre_status = tcpc_pkg::ST_LENGTH;
        end
        else if (s1_reg.proto_byte != tcpc_pkg::PROTO_TCP)
        begin
            s2_next.pre_status = tcpc_pkg::ST_NOT_TCP;
        end
        else if (toff1 > cnt1 || tlen1 < tcpc_pkg::MIN_HDR_BYTES)
        begin
            s2_next.pre_status = tcpc_pkg::ST_TCP_SHORT;
        end
        else
        begin
            s2_next.pre_status = tcpc_pkg::ST_OK;
        end
    end

    assign cnt2     = s2_reg.snap.count;
    assign toff2    = {s2_reg.snap.header_words, 2'b00};
    assign doff2    = {s2_reg.snap.data_offset, 2'b00};
    assign pstart   = {1'b0, toff2} + {1'b0, doff2};
    assign full_sum = tcpc_pkg::ones_add(tcpc_pkg::ones_add(s2_reg.addr_sum, s2_reg.len_sum),
                                         s2_reg.seg_sum);
    assign ack_set  = s2_reg.snap.flag_byte[4];

    always_comb
    begin
        out_next = '0;
        if (s2_reg.pre_status != tcpc_pkg::ST_OK)
        begin
            out_next.status = s2_reg.pre_status;
        end
        else if (full_sum != tcpc_pkg::SUM_GOOD)
        begin
            out_next.status = tcpc_pkg::ST_TCP_CKSUM;
        end
        else if ({10'd0, doff2} > s2_reg.tcp_len)
        begin
            out_next.status = tcpc_pkg::ST_OFFSET;
        end
        else
        begin
            out_next.status         = tcpc_pkg::ST_OK;
            out_next.source_ip      = s2_reg.snap.source_ip;
            out_next.dest_ip        = s2_reg.snap.dest_ip;
            out_next.source_port    = s2_reg.snap.source_port;
            out_next.dest_port      = s2_reg.snap.dest_port;
            out_next.hop_limit      = s2_reg.snap.ttl;
            out_next.window         = s2_reg.snap.window;
            out_next.seq_number     = s2_reg.snap.seq_number;
            out_next.ack_number     = ack_set ? s2_reg.snap.ack_number : 32'd0;
            out_next.flag_bits      = {ack_set, s2_reg.snap.flag_byte[2:0]};
            out_next.payload_start  = pstart;
            out_next.payload_length = cnt2[15:0] - {9'd0, pstart};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                s1_valid_reg <= snap_valid;
            end
            if (r2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (r3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && snap_valid)
        begin
            s1_reg <= snap;
        end
        if (r2 && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (r3 && s2_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    `TCPC_ASSERT_SAME(a_fields_zero_on_error,
        out_valid_reg && out_reg.status != tcpc_pkg::ST_OK,
        out_reg.source_ip == 32'd0 && out_reg.dest_ip == 32'd0 &&
        out_reg.seq_number == 32'd0 && out_reg.payload_length == 16'd0,
        "result fields not cleared on a failed packet")
    `TCPC_ASSERT_SAME(a_ack_needs_flag,
        out_valid_reg && !out_reg.flag_bits[3],
        out_reg.ack_number == 32'd0,
        "acknowledgement number reported without the ack flag")
    `TCPC_ASSERT_NEXT(a_mid_advances, s2_valid_reg && r3, out_valid_reg,
        "verdict stage did not move into the result register")

endmodule

@@ design/tcp_ipv4_packet_checker_top.sv @@
// Top level of the IPv4/TCP packet checker.
// Depends on tcpc_pkg, tcpc_parse and tcpc_verdict.
//
// The block takes an IPv4 packet one byte per item, with is_last on the final byte,
// and gives exactly one verdict item per packet. It accepts a byte in every cycle in
// which in_ready is high; the verdict passes the snapshot register, the checksum merge
// register and the result register before it is shown. in_ready falls only while all
// three verdict registers hold packets that the output side has not yet taken. The byte
// count saturates at 65536; longer packets give a length error (or an IP checksum one).
module tcp_ipv4_packet_checker_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pkt_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] source_ip,
    output logic [31:0] dest_ip,
    output logic [15:0] source_port,
    output logic [15:0] dest_port,
    output logic [7:0]  hop_limit,
    output logic [15:0] window,
    output logic [31:0] seq_number,
    output logic [31:0] ack_number,
    output logic [3:0]  flag_bits,
    output logic [6:0]  payload_start,
    output logic [15:0] payload_length
);

    logic            accept;
    logic            snap_ready;
    tcpc_pkg::snap_t snap;
    tcpc_pkg::res_t  result;

    assign accept   = in_valid && snap_ready;
    assign in_ready = snap_ready;

    tcpc_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (accept),
        .pkt_byte  (pkt_byte),
        .is_last   (is_last),
        .snap_next (snap)
    );

    tcpc_verdict u_verdict (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (accept && is_last),
        .snap_ready (snap_ready),
        .snap       (snap),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign status         = result.status;
    assign source_ip      = result.source_ip;
    assign dest_ip        = result.dest_ip;
    assign source_port    = result.source_port;
    assign dest_port      = result.dest_port;
    assign hop_limit      = result.hop_limit;
    assign window         = result.window;
    assign seq_number     = result.seq_number;
    assign ack_number     = result.ack_number;
    assign flag_bits      = result.flag_bits;
    assign payload_start  = result.payload_start;
    assign payload_length = result.payload_length;

endmodule
